// File: hdl/cdf_pkg.sv
// cdf_pkg: shared constants and types
// for the complex decimating fir core; no dependencies
`timescale 1ns / 1ps
package cdf_pkg;
   localparam int MAX_TAPS_DEF     = 64;
   localparam int SAMPLE_WIDTH_DEF = 16;
   localparam int COEF_WIDTH_DEF   = 16;
   localparam int REG_WIDTH        = 7;
   localparam int IDX_WIDTH        = 6;
   localparam int PHASE_LIMIT      = 64;
   localparam int LANES            = 8;

   localparam logic [0:0] CMD_SAMPLE = 1'b0;
   localparam logic [0:0] CMD_COEF   = 1'b1;

   localparam logic [0:0] REG_DECIMATION = 1'b0;
   localparam logic [0:0] REG_TAP_COUNT  = 1'b1;

   localparam int ACC_WIDTH = 48;

   typedef struct packed {
      logic start;
      logic last;
   } lane_ctl_type;
endpackage

// File: hdl/complex_decimating_fir_core.sv
// complex_decimating_fir_core: top level of the complex decimating fir
// depends on cdf_pkg, cdf_lane, cdf_merge
//
// usage: req_ transactions carry either one i/q sample (cmd 0) or one
// coefficient write (cmd 1). csr_ writes set decimation and tap count; the
// user must make them only while the core is idle, as the core does not
// enforce it. a sample on stream phase zero yields one rsp_ transaction.
// the sum is formed by LANES parallel mac lanes, each holding its own bank of
// MAX_TAPS/LANES delay and coefficient entries and walking them one per cycle;
// a merge stage adds the lane sums, rounds and saturates.
// a coefficient, or a sample not on phase zero, is taken without a stall; a
// sample on phase zero holds req_stall high through the lane walk, the
// accumulator, the merge register and the output load.
// reset clears the control, phase, delay lines and coefficients and restores
// decimation 1 and tap count 64. a stalled result holds in the output
// register while new transactions are still taken; a following result waits
// in the merge stage, with req_stall high, until the output register frees.
`timescale 1ns / 1ps
module complex_decimating_fir_core #(
   parameter int MAX_TAPS     = cdf_pkg::MAX_TAPS_DEF,
   parameter int SAMPLE_WIDTH = cdf_pkg::SAMPLE_WIDTH_DEF,
   parameter int COEF_WIDTH   = cdf_pkg::COEF_WIDTH_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic                            req_cmd,
   input  logic signed [SAMPLE_WIDTH-1:0]  req_sample_re,
   input  logic signed [SAMPLE_WIDTH-1:0]  req_sample_im,
   input  logic [cdf_pkg::IDX_WIDTH-1:0]   req_coef_index,
   input  logic signed [COEF_WIDTH-1:0]    req_coef_value,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic signed [SAMPLE_WIDTH-1:0]  rsp_out_re,
   output logic signed [SAMPLE_WIDTH-1:0]  rsp_out_im,
   input  logic                            csr_write,
   input  logic [0:0]                      csr_index,
   input  logic [cdf_pkg::REG_WIDTH-1:0]   csr_data
);
   import cdf_pkg::*;
   localparam int NL   = (MAX_TAPS < LANES) ? MAX_TAPS : LANES;
   localparam int STEPS = (MAX_TAPS + NL - 1) / NL;
   localparam int SW   = (STEPS > 1) ? $clog2(STEPS) : 1;
   localparam int TW   = $clog2(MAX_TAPS + 1);
   localparam int DEPTH = NL * STEPS;

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_WALK = 3'd1;
   localparam logic [2:0] ST_D1   = 3'd2;
   localparam logic [2:0] ST_D2   = 3'd3;
   localparam logic [2:0] ST_D3   = 3'd4;

   logic [2:0] state_ff, state_in;
   logic [SW-1:0] step_ff, step_in;
   logic [5:0] phase_ff, phase_in;
   logic [REG_WIDTH-1:0] dec_ff, taps_ff;
   logic signed [SAMPLE_WIDTH-1:0] tail_re [NL];
   logic signed [SAMPLE_WIDTH-1:0] tail_im [NL];
   logic signed [SAMPLE_WIDTH-1:0] ore_ff, oim_ff;
   logic ovalid_ff;
   logic accept, is_sample, emit, out_free;
   logic [6:0] d_eff, phase_next;
   logic [TW-1:0] taps_eff;
   logic signed [ACC_WIDTH-1:0] acc_re [NL];
   logic signed [ACC_WIDTH-1:0] acc_im [NL];
   logic signed [SAMPLE_WIDTH-1:0] res_re, res_im;
   lane_ctl_type ctl;

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign is_sample = (req_cmd == CMD_SAMPLE);
   assign emit      = accept && is_sample && (phase_ff == '0);
   assign out_free  = !ovalid_ff || !rsp_stall;

   always_comb begin
      d_eff = dec_ff;
      if (d_eff == '0) d_eff = 7'd1;
      if (d_eff > 7'(PHASE_LIMIT)) d_eff = 7'(PHASE_LIMIT);
      if (32'(d_eff) > MAX_TAPS) d_eff = 7'(MAX_TAPS);
      taps_eff = (32'(taps_ff) > MAX_TAPS) ? TW'(MAX_TAPS) : TW'(taps_ff);
      phase_next = 7'(phase_ff) + 7'd1;
      phase_in = phase_ff;
      if (accept && is_sample) phase_in = (phase_next >= d_eff) ? '0 : phase_next[5:0];
   end

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      ctl.start = 1'b0;
      ctl.last  = 1'b0;
      case (state_ff)
         ST_IDLE: if (emit) begin
            state_in = ST_WALK;
            step_in  = '0;
         end
         ST_WALK: begin
            ctl.start = (step_ff == '0);
            ctl.last  = (32'(step_ff) == STEPS - 1);
            if (ctl.last) state_in = ST_D1;
            else step_in = step_ff + SW'(1);
         end
         ST_D1: state_in = ST_D2;
         ST_D2: state_in = ST_D3;
         ST_D3: if (out_free) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         step_ff   <= '0;
         phase_ff  <= '0;
         dec_ff    <= 7'd1;
         taps_ff   <= 7'd64;
         ovalid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
         phase_ff <= phase_in;
         if (csr_write) begin
            case (csr_index)
               REG_DECIMATION: dec_ff  <= csr_data;
               REG_TAP_COUNT:  taps_ff <= csr_data;
               default: ;
            endcase
         end
         if ((state_ff == ST_D3) && out_free) ovalid_ff <= 1'b1;
         else if (ovalid_ff && !rsp_stall) ovalid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if ((state_ff == ST_D3) && out_free) begin
         ore_ff <= res_re;
         oim_ff <= res_im;
      end
   end

   genvar g;
   generate
      for (g = 0; g < NL; g++) begin : g_lane
         localparam int TAPW = $clog2(DEPTH > 1 ? DEPTH : 2) + 1;
         logic signed [SAMPLE_WIDTH-1:0] dre_ff [STEPS];
         logic signed [SAMPLE_WIDTH-1:0] dim_ff [STEPS];
         logic signed [COEF_WIDTH-1:0]   coef_ff [STEPS];
         logic signed [SAMPLE_WIDTH-1:0] shin_re, shin_im;
         logic [TAPW-1:0] tap;
         logic tap_en;
         logic coef_we;
         logic [SW-1:0] coef_addr;

         if (g == 0) begin : g_head
            assign shin_re = req_sample_re;
            assign shin_im = req_sample_im;
         end else begin : g_link
            assign shin_re = tail_re[g-1];
            assign shin_im = tail_im[g-1];
         end
         assign tail_re[g] = dre_ff[STEPS-1];
         assign tail_im[g] = dim_ff[STEPS-1];

         assign coef_we   = accept && !is_sample && (32'(req_coef_index) < MAX_TAPS) &&
                            (32'(req_coef_index) >= g * STEPS) &&
                            (32'(req_coef_index) < (g + 1) * STEPS);
         assign coef_addr = SW'(32'(req_coef_index) - 32'(g * STEPS));

         always_ff @(posedge clock) begin
            if (reset) begin
               for (int i = 0; i < STEPS; i++) begin
                  dre_ff[i]  <= '0;
                  dim_ff[i]  <= '0;
                  coef_ff[i] <= '0;
               end
            end else begin
               if (accept && is_sample) begin
                  dre_ff[0] <= shin_re;
                  dim_ff[0] <= shin_im;
                  for (int i = 1; i < STEPS; i++) begin
                     dre_ff[i] <= dre_ff[i-1];
                     dim_ff[i] <= dim_ff[i-1];
                  end
               end
               if (coef_we) coef_ff[coef_addr] <= req_coef_value;
            end
         end

         assign tap    = TAPW'(g * STEPS) + TAPW'(step_ff);
         assign tap_en = (state_ff == ST_WALK) && (32'(tap) < 32'(taps_eff));
         cdf_lane #(.SAMPLE_WIDTH(SAMPLE_WIDTH), .COEF_WIDTH(COEF_WIDTH)) u_lane (
            .clock (clock),
            .ctl   (ctl),
            .tap_en(tap_en),
            .coef  (coef_ff[step_ff]),
            .x_re  (dre_ff[step_ff]),
            .x_im  (dim_ff[step_ff]),
            .acc_re(acc_re[g]),
            .acc_im(acc_im[g])
         );
      end
   endgenerate

   cdf_merge #(.NLANES(NL), .SAMPLE_WIDTH(SAMPLE_WIDTH), .COEF_WIDTH(COEF_WIDTH)) u_merge_re (
      .clock(clock), .lane_acc(acc_re), .result(res_re));
   cdf_merge #(.NLANES(NL), .SAMPLE_WIDTH(SAMPLE_WIDTH), .COEF_WIDTH(COEF_WIDTH)) u_merge_im (
      .clock(clock), .lane_acc(acc_im), .result(res_im));

   assign rsp_valid  = ovalid_ff;
   assign rsp_out_re = ore_ff;
   assign rsp_out_im = oim_ff;

`ifndef SYNTHESIS
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> !accept) else $error("accept while busy");
   a_emit_walk: assert property (@(posedge clock) disable iff (reset)
      emit |=> (state_ff == ST_WALK)) else $error("emit did not start walk");
   a_out_from_d3: assert property (@(posedge clock) disable iff (reset)
      $rose(ovalid_ff) |-> $past(state_ff == ST_D3)) else $error("spurious result");
`endif
endmodule

// File: hdl/cdf_lane.sv
// cdf_lane: one multiply-accumulate lane for i and q with shared coefficient
// depends on cdf_pkg
`timescale 1ns / 1ps
module cdf_lane #(
   parameter int SAMPLE_WIDTH = cdf_pkg::SAMPLE_WIDTH_DEF,
   parameter int COEF_WIDTH   = cdf_pkg::COEF_WIDTH_DEF
) (
   input  logic                                 clock,
   input  cdf_pkg::lane_ctl_type                ctl,
   input  logic                                 tap_en,
   input  logic signed [COEF_WIDTH-1:0]         coef,
   input  logic signed [SAMPLE_WIDTH-1:0]       x_re,
   input  logic signed [SAMPLE_WIDTH-1:0]       x_im,
   output logic signed [cdf_pkg::ACC_WIDTH-1:0] acc_re,
   output logic signed [cdf_pkg::ACC_WIDTH-1:0] acc_im
);
   import cdf_pkg::*;
   localparam int PW = SAMPLE_WIDTH + COEF_WIDTH;
   logic signed [PW-1:0] prod_re_ff, prod_im_ff;
   logic signed [PW-1:0] prod_re_in, prod_im_in;
   logic                 start_ff;
   logic signed [ACC_WIDTH-1:0] acc_re_ff, acc_im_ff;

   assign prod_re_in = tap_en ? PW'(coef * x_re) : '0;
   assign prod_im_in = tap_en ? PW'(coef * x_im) : '0;

   always_ff @(posedge clock) begin
      prod_re_ff <= prod_re_in;
      prod_im_ff <= prod_im_in;
      start_ff   <= ctl.start;
      if (start_ff) begin
         acc_re_ff <= ACC_WIDTH'(prod_re_ff);
         acc_im_ff <= ACC_WIDTH'(prod_im_ff);
      end else begin
         acc_re_ff <= acc_re_ff + ACC_WIDTH'(prod_re_ff);
         acc_im_ff <= acc_im_ff + ACC_WIDTH'(prod_im_ff);
      end
   end

   assign acc_re = acc_re_ff;
   assign acc_im = acc_im_ff;
endmodule

// File: hdl/cdf_merge.sv
// cdf_merge: adds the lane sums, rounds half up, shifts and saturates
// depends on cdf_pkg
`timescale 1ns / 1ps
module cdf_merge #(
   parameter int NLANES       = cdf_pkg::LANES,
   parameter int SAMPLE_WIDTH = cdf_pkg::SAMPLE_WIDTH_DEF,
   parameter int COEF_WIDTH   = cdf_pkg::COEF_WIDTH_DEF
) (
   input  logic                                   clock,
   input  logic signed [cdf_pkg::ACC_WIDTH-1:0]   lane_acc [NLANES],
   output logic signed [SAMPLE_WIDTH-1:0]         result
);
   import cdf_pkg::*;
   logic signed [ACC_WIDTH-1:0] sum_ff, sum_in, v;
   logic signed [ACC_WIDTH-1:0] q;
   localparam logic signed [ACC_WIDTH-1:0] MAXV = ACC_WIDTH'((64'sd1 << (SAMPLE_WIDTH-1)) - 1);
   localparam logic signed [ACC_WIDTH-1:0] MINV = -MAXV - 1;

   always_comb begin
      sum_in = '0;
      for (int i = 0; i < NLANES; i++) sum_in = sum_in + lane_acc[i];
   end

   always_ff @(posedge clock) sum_ff <= sum_in;

   always_comb begin
      v = sum_ff + (ACC_WIDTH'(1) <<< (COEF_WIDTH-2));
      q = v >>> (COEF_WIDTH-1);
      if (q > MAXV)      result = MAXV[SAMPLE_WIDTH-1:0];
      else if (q < MINV) result = MINV[SAMPLE_WIDTH-1:0];
      else               result = q[SAMPLE_WIDTH-1:0];
   end
endmodule
